// ----- rtl/jbp_pkg.sv -----
// Shared types, opcode constants and the opcode classifier for the JVM
// bytecode predecoder. No dependencies.
package jbp_pkg;

  localparam logic [7:0] OP_BIPUSH          = 8'h10;
  localparam logic [7:0] OP_SIPUSH          = 8'h11;
  localparam logic [7:0] OP_LDC             = 8'h12;
  localparam logic [7:0] OP_LDC_W           = 8'h13;
  localparam logic [7:0] OP_LDC2_W          = 8'h14;
  localparam logic [7:0] OP_ILOAD           = 8'h15;
  localparam logic [7:0] OP_ALOAD           = 8'h19;
  localparam logic [7:0] OP_ISTORE          = 8'h36;
  localparam logic [7:0] OP_ASTORE          = 8'h3A;
  localparam logic [7:0] OP_IINC            = 8'h84;
  localparam logic [7:0] OP_IFEQ            = 8'h99;
  localparam logic [7:0] OP_JSR             = 8'hA8;
  localparam logic [7:0] OP_RET             = 8'hA9;
  localparam logic [7:0] OP_TABLESWITCH     = 8'hAA;
  localparam logic [7:0] OP_LOOKUPSWITCH    = 8'hAB;
  localparam logic [7:0] OP_IRETURN         = 8'hAC;
  localparam logic [7:0] OP_RETURN          = 8'hB1;
  localparam logic [7:0] OP_GETSTATIC       = 8'hB2;
  localparam logic [7:0] OP_INVOKEVIRTUAL   = 8'hB6;
  localparam logic [7:0] OP_INVOKESTATIC    = 8'hB8;
  localparam logic [7:0] OP_INVOKEINTERFACE = 8'hB9;
  localparam logic [7:0] OP_INVOKEDYNAMIC   = 8'hBA;
  localparam logic [7:0] OP_NEW             = 8'hBB;
  localparam logic [7:0] OP_NEWARRAY        = 8'hBC;
  localparam logic [7:0] OP_ANEWARRAY       = 8'hBD;
  localparam logic [7:0] OP_ATHROW          = 8'hBF;
  localparam logic [7:0] OP_CHECKCAST       = 8'hC0;
  localparam logic [7:0] OP_INSTANCEOF      = 8'hC1;
  localparam logic [7:0] OP_WIDE            = 8'hC4;
  localparam logic [7:0] OP_MULTIANEWARRAY  = 8'hC5;
  localparam logic [7:0] OP_IFNULL          = 8'hC6;
  localparam logic [7:0] OP_IFNONNULL       = 8'hC7;
  localparam logic [7:0] OP_GOTO_W          = 8'hC8;
  localparam logic [7:0] OP_JSR_W           = 8'hC9;
  localparam logic [7:0] OP_UNUSED_FIRST    = 8'hCB;
  localparam logic [7:0] OP_UNUSED_LAST     = 8'hFD;

  typedef enum logic [4:0] {
    K_NONE, K_U1, K_S1, K_S2, K_CP1, K_CP2, K_IINC, K_BR2, K_BR4, K_NEWARR,
    K_IFACE, K_IDYN, K_MULTI, K_TBL, K_LKP, K_WIDE, K_BAD
  } kind_t;

  typedef struct packed {
    logic [63:0] window_low;
    logic [63:0] window_high;
    logic [31:0] bytes_left;
    logic [1:0]  offset_mod_four;
    logic [63:0] address;
  } in_item_t;

  typedef struct packed {
    logic               ok;
    logic [31:0]        length;
    logic [7:0]         effective_opcode;
    logic               is_wide;
    logic [15:0]        index_operand;
    logic signed [15:0] immediate;
    logic [7:0]         extra_byte;
    logic [63:0]        branch_target;
    logic [29:0]        switch_count;
    logic               is_call;
    logic               is_return;
    logic               is_branch;
  } out_item_t;

  function automatic kind_t kind_of(input logic [7:0] op);
    kind_t k;
    if (op == OP_BIPUSH) k = K_S1;
    else if (op == OP_SIPUSH) k = K_S2;
    else if (op == OP_LDC) k = K_CP1;
    else if (op == OP_LDC_W || op == OP_LDC2_W) k = K_CP2;
    else if ((op >= OP_ILOAD && op <= OP_ALOAD) || (op >= OP_ISTORE && op <= OP_ASTORE) ||
             op == OP_RET) k = K_U1;
    else if (op == OP_IINC) k = K_IINC;
    else if ((op >= OP_IFEQ && op <= OP_JSR) || op == OP_IFNULL || op == OP_IFNONNULL)
      k = K_BR2;
    else if (op == OP_TABLESWITCH) k = K_TBL;
    else if (op == OP_LOOKUPSWITCH) k = K_LKP;
    else if ((op >= OP_GETSTATIC && op <= OP_INVOKESTATIC) || op == OP_NEW ||
             op == OP_ANEWARRAY || op == OP_CHECKCAST || op == OP_INSTANCEOF) k = K_CP2;
    else if (op == OP_INVOKEINTERFACE) k = K_IFACE;
    else if (op == OP_INVOKEDYNAMIC) k = K_IDYN;
    else if (op == OP_NEWARRAY) k = K_NEWARR;
    else if (op == OP_WIDE) k = K_WIDE;
    else if (op == OP_MULTIANEWARRAY) k = K_MULTI;
    else if (op == OP_GOTO_W || op == OP_JSR_W) k = K_BR4;
    else if (op >= OP_UNUSED_FIRST && op <= OP_UNUSED_LAST) k = K_BAD;
    else k = K_NONE;
    return k;
  endfunction

endpackage

// ----- rtl/jbp_if.sv -----
// Valid/ready channel interfaces for the predecoder's window and result streams.
// Depends on nothing; payload widths follow the field definitions.
interface jbp_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] window_low;
  logic [63:0] window_high;
  logic [31:0] bytes_left;
  logic [1:0]  offset_mod_four;
  logic [63:0] address;

  modport source (output valid, window_low, window_high, bytes_left, offset_mod_four,
                  address, input ready);
  modport sink (input valid, window_low, window_high, bytes_left, offset_mod_four,
                address, output ready);
endinterface

interface jbp_out_if;
  logic               valid;
  logic               ready;
  logic               ok;
  logic [31:0]        length;
  logic [7:0]         effective_opcode;
  logic               is_wide;
  logic [15:0]        index_operand;
  logic signed [15:0] immediate;
  logic [7:0]         extra_byte;
  logic [63:0]        branch_target;
  logic [29:0]        switch_count;
  logic               is_call;
  logic               is_return;
  logic               is_branch;

  modport source (output valid, ok, length, effective_opcode, is_wide, index_operand,
                  immediate, extra_byte, branch_target, switch_count, is_call,
                  is_return, is_branch, input ready);
  modport sink (input valid, ok, length, effective_opcode, is_wide, index_operand,
                immediate, extra_byte, branch_target, switch_count, is_call,
                is_return, is_branch, output ready);
endinterface

// ----- rtl/jvm_bytecode_predecoder_top.sv -----
// Top level of the JVM bytecode predecoder: input register, decoder, result register.
// Depends on jbp_pkg, jbp_in_if, jbp_out_if and jbp_decode.
//
// Usage:
//   in_ch carries one 16-byte code window per transaction, with the bytes
//   available, the code offset modulo four and the address of the opcode.
//   out_ch returns one decode result per input transaction, in order.
//   Every window is decoded on its own; there is no state between items.
// Timing:
//   An accepted transaction is captured in the input register, decoded by
//   single-pass logic and captured in the result register once that register
//   is free; out_ch.valid then rises with the registered result.
//   One transaction per cycle is sustained while out_ch.ready stays high; the
//   decoder path (switch entry count against bytes available, and the 64-bit
//   target add) sets the clock period.
// Reset and stall:
//   rst_n low clears both stage valid flags; nothing else is initialised.
//   While out_ch.ready is low the result register holds, the input register
//   still takes one more transaction, and in_ch.ready then drops until the
//   result is taken.
module jvm_bytecode_predecoder_top (
  input  logic           clk,
  input  logic           rst_n,
  jbp_in_if.sink         in_ch,
  jbp_out_if.source      out_ch
);

  logic               s0_v_r;
  logic               s0_v_nxt;
  logic               s1_v_r;
  logic               s1_v_nxt;
  logic               s0_take;
  logic               s1_take;
  jbp_pkg::in_item_t  in_r;
  jbp_pkg::out_item_t out_r;
  jbp_pkg::out_item_t dec;

  assign s1_take     = !s1_v_r || out_ch.ready;
  assign s0_take     = !s0_v_r || s1_take;
  assign in_ch.ready = s0_take;

  always_comb begin
    s0_v_nxt = s0_take ? in_ch.valid : s0_v_r;
    s1_v_nxt = s1_take ? s0_v_r : s1_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
      s1_v_r <= 1'b0;
    end else begin
      s0_v_r <= s0_v_nxt;
      s1_v_r <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_take && in_ch.valid) begin
      in_r.window_low      <= in_ch.window_low;
      in_r.window_high     <= in_ch.window_high;
      in_r.bytes_left      <= in_ch.bytes_left;
      in_r.offset_mod_four <= in_ch.offset_mod_four;
      in_r.address         <= in_ch.address;
    end
    if (s1_take && s0_v_r) begin
      out_r <= dec;
    end
  end

  jbp_decode u_decode (
    .item (in_r),
    .res  (dec)
  );

  assign out_ch.valid            = s1_v_r;
  assign out_ch.ok               = out_r.ok;
  assign out_ch.length           = out_r.length;
  assign out_ch.effective_opcode = out_r.effective_opcode;
  assign out_ch.is_wide          = out_r.is_wide;
  assign out_ch.index_operand    = out_r.index_operand;
  assign out_ch.immediate        = out_r.immediate;
  assign out_ch.extra_byte       = out_r.extra_byte;
  assign out_ch.branch_target    = out_r.branch_target;
  assign out_ch.switch_count     = out_r.switch_count;
  assign out_ch.is_call          = out_r.is_call;
  assign out_ch.is_return        = out_r.is_return;
  assign out_ch.is_branch        = out_r.is_branch;

endmodule

// ----- rtl/jbp_decode.sv -----
// Combinational instruction decoder: one registered window in, one result out.
// Depends on jbp_pkg for the item structs, opcode constants and classifier.
module jbp_decode (
  input  jbp_pkg::in_item_t  item,
  output jbp_pkg::out_item_t res
);

  logic [7:0]  b [16];
  logic [31:0] n;
  logic [1:0]  pad;
  logic [3:0]  q;
  logic [7:0]  op;
  logic [7:0]  sub;
  logic [15:0] rd16_1;
  logic [15:0] rd16_2;
  logic [15:0] rd16_4;
  logic [31:0] rd32_1;
  logic [31:0] sw_dflt;
  logic [31:0] sw_w1;
  logic [31:0] sw_w2;
  logic [4:0]  tbl_need;
  logic [4:0]  lkp_need;
  logic [31:0] tbl_diff;
  logic [31:0] lkp_diff;
  logic [31:0] tbl_lo;
  logic [31:0] tbl_hi;
  logic [32:0] tbl_cnt;
  logic [63:0] br2_tgt;
  logic [63:0] br4_tgt;
  logic [63:0] sw_tgt;
  jbp_pkg::kind_t kind;
  logic        ok;

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      b[k]     = item.window_low[8*k +: 8];
      b[k + 8] = item.window_high[8*k +: 8];
    end
    n      = item.bytes_left;
    pad    = 2'd3 - item.offset_mod_four;
    q      = 4'd1 + {2'b00, pad};
    op     = b[0];
    sub    = b[1];
    rd16_1 = {b[1], b[2]};
    rd16_2 = {b[2], b[3]};
    rd16_4 = {b[4], b[5]};
    rd32_1 = {b[1], b[2], b[3], b[4]};
    sw_dflt = {b[q], b[q + 4'd1], b[q + 4'd2], b[q + 4'd3]};
    sw_w1   = {b[q + 4'd4], b[q + 4'd5], b[q + 4'd6], b[q + 4'd7]};
    sw_w2   = {b[q + 4'd8], b[q + 4'd9], b[q + 4'd10], b[q + 4'd11]};
    tbl_need = 5'd13 + {3'b000, pad};
    lkp_need = 5'd9 + {3'b000, pad};
    tbl_diff = n - {27'd0, tbl_need};
    lkp_diff = n - {27'd0, lkp_need};
    tbl_lo   = sw_w1 ^ 32'h8000_0000;
    tbl_hi   = sw_w2 ^ 32'h8000_0000;
    tbl_cnt  = {1'b0, tbl_hi - tbl_lo} + 33'd1;
    br2_tgt  = item.address + {{48{rd16_1[15]}}, rd16_1};
    br4_tgt  = item.address + {{32{rd32_1[31]}}, rd32_1};
    sw_tgt   = item.address + {{32{sw_dflt[31]}}, sw_dflt};
    kind     = (n == 32'd0) ? jbp_pkg::K_BAD : jbp_pkg::kind_of(op);

    ok  = 1'b1;
    res = '0;
    res.length = 32'd1;
    res.effective_opcode = op;

    unique case (kind)
      jbp_pkg::K_NONE: begin
      end
      jbp_pkg::K_U1, jbp_pkg::K_CP1: begin
        if (n < 32'd2) ok = 1'b0;
        res.length = 32'd2;
        res.index_operand = {8'd0, b[1]};
      end
      jbp_pkg::K_S1: begin
        if (n < 32'd2) ok = 1'b0;
        res.length = 32'd2;
        res.immediate = {{8{b[1][7]}}, b[1]};
      end
      jbp_pkg::K_S2: begin
        if (n < 32'd3) ok = 1'b0;
        res.length = 32'd3;
        res.immediate = rd16_1;
      end
      jbp_pkg::K_CP2: begin
        if (n < 32'd3) ok = 1'b0;
        res.length = 32'd3;
        res.index_operand = rd16_1;
      end
      jbp_pkg::K_IINC: begin
        if (n < 32'd3) ok = 1'b0;
        res.length = 32'd3;
        res.index_operand = {8'd0, b[1]};
        res.immediate = {{8{b[2][7]}}, b[2]};
      end
      jbp_pkg::K_BR2: begin
        if (n < 32'd3 || br2_tgt[63]) ok = 1'b0;
        res.length = 32'd3;
        res.branch_target = br2_tgt;
      end
      jbp_pkg::K_BR4: begin
        if (n < 32'd5 || br4_tgt[63]) ok = 1'b0;
        res.length = 32'd5;
        res.branch_target = br4_tgt;
      end
      jbp_pkg::K_NEWARR: begin
        if (n < 32'd2) ok = 1'b0;
        res.length = 32'd2;
        res.extra_byte = b[1];
      end
      jbp_pkg::K_IFACE: begin
        if (n < 32'd5) ok = 1'b0;
        res.length = 32'd5;
        res.index_operand = rd16_1;
        res.extra_byte = b[3];
      end
      jbp_pkg::K_IDYN: begin
        if (n < 32'd5) ok = 1'b0;
        res.length = 32'd5;
        res.index_operand = rd16_1;
      end
      jbp_pkg::K_MULTI: begin
        if (n < 32'd4) ok = 1'b0;
        res.length = 32'd4;
        res.index_operand = rd16_1;
        res.extra_byte = b[3];
      end
      jbp_pkg::K_TBL: begin
        if (n < {27'd0, tbl_need} || tbl_hi < tbl_lo ||
            tbl_cnt > {3'b000, tbl_diff[31:2]}) ok = 1'b0;
        res.switch_count = tbl_cnt[29:0];
        res.length = {27'd0, tbl_need} + {tbl_cnt[29:0], 2'b00};
        res.branch_target = sw_tgt;
      end
      jbp_pkg::K_LKP: begin
        if (n < {27'd0, lkp_need} || sw_w1[31] ||
            sw_w1 > {3'b000, lkp_diff[31:3]}) ok = 1'b0;
        res.switch_count = sw_w1[29:0];
        res.length = {27'd0, lkp_need} + {sw_w1[28:0], 3'b000};
        res.branch_target = sw_tgt;
      end
      jbp_pkg::K_WIDE: begin
        res.is_wide = 1'b1;
        res.effective_opcode = sub;
        if (n < 32'd2) begin
          ok = 1'b0;
        end else if (sub == jbp_pkg::OP_IINC) begin
          if (n < 32'd6) ok = 1'b0;
          res.length = 32'd6;
          res.index_operand = rd16_2;
          res.immediate = rd16_4;
        end else if (jbp_pkg::kind_of(sub) == jbp_pkg::K_U1) begin
          if (n < 32'd4) ok = 1'b0;
          res.length = 32'd4;
          res.index_operand = rd16_2;
        end else begin
          ok = 1'b0;
        end
      end
      jbp_pkg::K_BAD: begin
        ok = 1'b0;
      end
      default: begin
        ok = 1'b0;
      end
    endcase

    if (ok) begin
      res.ok = 1'b1;
      if (op >= jbp_pkg::OP_INVOKEVIRTUAL && op <= jbp_pkg::OP_INVOKEDYNAMIC) begin
        res.is_call   = 1'b1;
        res.is_branch = 1'b1;
      end else if ((op >= jbp_pkg::OP_IRETURN && op <= jbp_pkg::OP_RETURN) ||
                   op == jbp_pkg::OP_ATHROW || op == jbp_pkg::OP_RET ||
                   (op == jbp_pkg::OP_WIDE && sub == jbp_pkg::OP_RET)) begin
        res.is_return = 1'b1;
        res.is_branch = 1'b1;
      end else if ((op >= jbp_pkg::OP_IFEQ && op <= jbp_pkg::OP_JSR) ||
                   (op >= jbp_pkg::OP_IFNULL && op <= jbp_pkg::OP_JSR_W) ||
                   op == jbp_pkg::OP_TABLESWITCH || op == jbp_pkg::OP_LOOKUPSWITCH) begin
        res.is_branch = 1'b1;
      end
    end else begin
      res = '0;
      res.length = 32'd1;
    end
  end

endmodule

// ----- sim/jbp_check_pkg.sv -----
// Decode predictor and result scoreboard for the JVM bytecode predecoder testbench.
// Depends on jbp_pkg for the transaction types, opcode constants and kind_t.
package jbp_check_pkg;
  timeunit 1ns;
  timeprecision 1ps;

  import jbp_pkg::*;

  localparam logic [63:0] SWITCH_PAD_BASE = 64'd3;

  function automatic logic [7:0] code_byte(input logic [127:0] w, input int unsigned k);
    return w[8*(k%16) +: 8];
  endfunction

  function automatic logic [15:0] code_be16(input logic [127:0] w, input int unsigned k);
    return {code_byte(w, k), code_byte(w, k + 1)};
  endfunction

  function automatic logic [31:0] code_be32(input logic [127:0] w, input int unsigned k);
    return {code_be16(w, k), code_be16(w, k + 2)};
  endfunction

  function automatic logic [63:0] widen32(input logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

  function automatic kind_t opcode_kind(input logic [7:0] op);
    kind_t k;
    case (op)
      OP_BIPUSH:                  k = K_S1;
      OP_SIPUSH:                  k = K_S2;
      OP_LDC:                     k = K_CP1;
      OP_LDC_W, OP_LDC2_W, OP_NEW, OP_ANEWARRAY,
      OP_CHECKCAST, OP_INSTANCEOF: k = K_CP2;
      OP_RET:                     k = K_U1;
      OP_IINC:                    k = K_IINC;
      OP_IFNULL, OP_IFNONNULL:    k = K_BR2;
      OP_GOTO_W, OP_JSR_W:        k = K_BR4;
      OP_TABLESWITCH:             k = K_TBL;
      OP_LOOKUPSWITCH:            k = K_LKP;
      OP_INVOKEINTERFACE:         k = K_IFACE;
      OP_INVOKEDYNAMIC:           k = K_IDYN;
      OP_NEWARRAY:                k = K_NEWARR;
      OP_WIDE:                    k = K_WIDE;
      OP_MULTIANEWARRAY:          k = K_MULTI;
      default: begin
        if ((op >= OP_ILOAD && op <= OP_ALOAD) || (op >= OP_ISTORE && op <= OP_ASTORE))
          k = K_U1;
        else if (op >= OP_IFEQ && op <= OP_JSR) k = K_BR2;
        else if (op >= OP_GETSTATIC && op <= OP_INVOKESTATIC) k = K_CP2;
        else if (op >= OP_UNUSED_FIRST && op <= OP_UNUSED_LAST) k = K_BAD;
        else k = K_NONE;
      end
    endcase
    return k;
  endfunction

  function automatic out_item_t decode_window(input in_item_t it);
    out_item_t   r;
    logic [127:0] w;
    logic [63:0] avail, pad, len, cnt, room, tgt;
    logic [31:0] lo_b, hi_b;
    logic [15:0] rel16;
    logic [7:0]  op, b1, b2, b3;
    int unsigned q;
    kind_t       k;
    bit          ok;
    r     = '0;
    ok    = 1'b1;
    len   = 64'd1;
    w     = {it.window_high, it.window_low};
    op    = code_byte(w, 0);
    b1    = code_byte(w, 1);
    b2    = code_byte(w, 2);
    b3    = code_byte(w, 3);
    avail = 64'(it.bytes_left);
    pad   = SWITCH_PAD_BASE - 64'(it.offset_mod_four);
    q     = 1 + 32'(pad);
    r.effective_opcode = op;
    k = (avail == 0) ? K_BAD : opcode_kind(op);
    case (k)
      K_NONE: ;
      K_U1, K_CP1: begin
        if (avail < 2) ok = 1'b0;
        else begin
          len = 2;
          r.index_operand = {8'h00, b1};
        end
      end
      K_S1: begin
        if (avail < 2) ok = 1'b0;
        else begin
          len = 2;
          r.immediate = {{8{b1[7]}}, b1};
        end
      end
      K_S2: begin
        if (avail < 3) ok = 1'b0;
        else begin
          len = 3;
          r.immediate = code_be16(w, 1);
        end
      end
      K_CP2: begin
        if (avail < 3) ok = 1'b0;
        else begin
          len = 3;
          r.index_operand = code_be16(w, 1);
        end
      end
      K_IINC: begin
        if (avail < 3) ok = 1'b0;
        else begin
          len = 3;
          r.index_operand = {8'h00, b1};
          r.immediate     = {{8{b2[7]}}, b2};
        end
      end
      K_BR2, K_BR4: begin
        if (avail < ((k == K_BR2) ? 64'd3 : 64'd5)) ok = 1'b0;
        else begin
          rel16 = code_be16(w, 1);
          if (k == K_BR2) begin
            len = 3;
            tgt = it.address + {{48{rel16[15]}}, rel16};
          end else begin
            len = 5;
            tgt = it.address + widen32(code_be32(w, 1));
          end
          r.branch_target = tgt;
          if (tgt[63]) ok = 1'b0;
        end
      end
      K_NEWARR: begin
        if (avail < 2) ok = 1'b0;
        else begin
          len = 2;
          r.extra_byte = b1;
        end
      end
      K_IFACE: begin
        if (avail < 5) ok = 1'b0;
        else begin
          len = 5;
          r.index_operand = code_be16(w, 1);
          r.extra_byte    = b3;
        end
      end
      K_IDYN: begin
        if (avail < 5) ok = 1'b0;
        else begin
          len = 5;
          r.index_operand = code_be16(w, 1);
        end
      end
      K_MULTI: begin
        if (avail < 4) ok = 1'b0;
        else begin
          len = 4;
          r.index_operand = code_be16(w, 1);
          r.extra_byte    = b3;
        end
      end
      K_TBL: begin
        if (avail < 13 + pad) ok = 1'b0;
        else begin
          lo_b = code_be32(w, q + 4) ^ 32'h8000_0000;
          hi_b = code_be32(w, q + 8) ^ 32'h8000_0000;
          if (hi_b < lo_b) ok = 1'b0;
          else begin
            cnt  = 64'(hi_b) - 64'(lo_b) + 64'd1;
            room = (avail - 13 - pad) / 4;
            if (cnt > room) ok = 1'b0;
            else begin
              len = 13 + pad + cnt * 4;
              r.switch_count  = cnt[29:0];
              r.branch_target = it.address + widen32(code_be32(w, q));
            end
          end
        end
      end
      K_LKP: begin
        if (avail < 9 + pad) ok = 1'b0;
        else begin
          hi_b = code_be32(w, q + 4);
          room = (avail - 9 - pad) / 8;
          if (hi_b[31] || 64'(hi_b) > room) ok = 1'b0;
          else begin
            len = 9 + pad + 64'(hi_b) * 8;
            r.switch_count  = hi_b[29:0];
            r.branch_target = it.address + widen32(code_be32(w, q));
          end
        end
      end
      K_WIDE: begin
        if (avail < 2) ok = 1'b0;
        else if (b1 == OP_IINC) begin
          if (avail < 6) ok = 1'b0;
          else begin
            len = 6;
            r.index_operand = code_be16(w, 2);
            r.immediate     = code_be16(w, 4);
          end
        end else if (opcode_kind(b1) == K_U1) begin
          if (avail < 4) ok = 1'b0;
          else begin
            len = 4;
            r.index_operand = code_be16(w, 2);
          end
        end else ok = 1'b0;
        r.is_wide          = 1'b1;
        r.effective_opcode = b1;
      end
      default: ok = 1'b0;
    endcase

    if (ok) begin
      if (op >= OP_INVOKEVIRTUAL && op <= OP_INVOKEDYNAMIC) begin
        r.is_call   = 1'b1;
        r.is_branch = 1'b1;
      end else if ((op >= OP_IRETURN && op <= OP_RETURN) || op == OP_ATHROW || op == OP_RET ||
                   (op == OP_WIDE && b1 == OP_RET)) begin
        r.is_return = 1'b1;
        r.is_branch = 1'b1;
      end else if ((op >= OP_IFEQ && op <= OP_JSR) || (op >= OP_IFNULL && op <= OP_JSR_W) ||
                   op == OP_TABLESWITCH || op == OP_LOOKUPSWITCH) begin
        r.is_branch = 1'b1;
      end
    end else begin
      r = '0;
    end
    r.ok     = ok;
    r.length = ok ? len[31:0] : 32'd1;
    return r;
  endfunction

  class decode_scoreboard;
    out_item_t   pending_decodes[$];
    int unsigned fault_count;

    function new();
      fault_count = 0;
    endfunction

    function void note_window(input in_item_t it);
      pending_decodes = {pending_decodes, decode_window(it)};
    endfunction

    function int unsigned outstanding();
      return pending_decodes.size();
    endfunction

    function void flag_field(input string field, input logic [63:0] want,
                             input logic [63:0] got);
      if (want !== got) begin
        fault_count++;
        $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, field, want, got);
      end
    endfunction

    function void check_decode(input out_item_t got);
      out_item_t want;
      if (pending_decodes.size() == 0) begin
        fault_count++;
        $display("%0t ns: unexpected result, expected none, got length %0h",
                 $time, got.length);
        return;
      end
      want = pending_decodes.pop_front();
      flag_field("ok", want.ok, got.ok);
      flag_field("length", want.length, got.length);
      flag_field("effective_opcode", want.effective_opcode, got.effective_opcode);
      flag_field("is_wide", want.is_wide, got.is_wide);
      flag_field("index_operand", want.index_operand, got.index_operand);
      flag_field("immediate", want.immediate, got.immediate);
      flag_field("extra_byte", want.extra_byte, got.extra_byte);
      flag_field("branch_target", want.branch_target, got.branch_target);
      flag_field("switch_count", want.switch_count, got.switch_count);
      flag_field("is_call", want.is_call, got.is_call);
      flag_field("is_return", want.is_return, got.is_return);
      flag_field("is_branch", want.is_branch, got.is_branch);
    endfunction

    function void check_drained();
      if (pending_decodes.size() != 0) begin
        fault_count += pending_decodes.size();
        $display("%0t ns: %0d results missing, expected length %0h first, got none",
                 $time, pending_decodes.size(), pending_decodes[0].length);
      end
    endfunction
  endclass

endpackage

// ----- sim/tb_top.sv -----
// Top-level testbench for jvm_bytecode_predecoder_top: directed and random code windows,
// random source gaps and sink stalls. Depends on jbp_pkg, jbp_if and jbp_check_pkg.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import jbp_pkg::*;
  import jbp_check_pkg::*;

  logic clk = 1'b0;
  logic rst_n;

  jbp_in_if  in_ch();
  jbp_out_if out_ch();

  decode_scoreboard decode_sb;
  int unsigned      send_idle_pct = 0;
  int unsigned      stall_pct = 0;

  jvm_bytecode_predecoder_top i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin : watch
    in_item_t  seen_in;
    out_item_t seen_out;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        seen_in.window_low      = in_ch.window_low;
        seen_in.window_high     = in_ch.window_high;
        seen_in.bytes_left      = in_ch.bytes_left;
        seen_in.offset_mod_four = in_ch.offset_mod_four;
        seen_in.address         = in_ch.address;
        decode_sb.note_window(seen_in);
      end
      if (out_ch.valid && out_ch.ready) begin
        seen_out.ok               = out_ch.ok;
        seen_out.length           = out_ch.length;
        seen_out.effective_opcode = out_ch.effective_opcode;
        seen_out.is_wide          = out_ch.is_wide;
        seen_out.index_operand    = out_ch.index_operand;
        seen_out.immediate        = out_ch.immediate;
        seen_out.extra_byte       = out_ch.extra_byte;
        seen_out.branch_target    = out_ch.branch_target;
        seen_out.switch_count     = out_ch.switch_count;
        seen_out.is_call          = out_ch.is_call;
        seen_out.is_return        = out_ch.is_return;
        seen_out.is_branch        = out_ch.is_branch;
        decode_sb.check_decode(seen_out);
      end
    end
  end

  function automatic logic [127:0] put_be32(input logic [127:0] w, input int unsigned k,
                                            input logic [31:0] v);
    logic [127:0] r;
    r = w;
    for (int i = 0; i < 4; i++) r[8*((k + i) % 16) +: 8] = v[8*(3 - i) +: 8];
    return r;
  endfunction

  task automatic send_window(input in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.window_low      <= it.window_low;
    in_ch.window_high     <= it.window_high;
    in_ch.bytes_left      <= it.bytes_left;
    in_ch.offset_mod_four <= it.offset_mod_four;
    in_ch.address         <= it.address;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // code holds nb bytes, opcode in the most significant one; the rest is filler
  task automatic send_code(input logic [127:0] code, input int unsigned nb,
                           input logic [31:0] avail, input logic [1:0] om4,
                           input logic [63:0] va);
    in_item_t     it;
    logic [127:0] w;
    w = {$urandom, $urandom, $urandom, $urandom};
    for (int k = 0; k < nb; k++) w[8*k +: 8] = code[8*(nb - 1 - k) +: 8];
    it.window_low      = w[63:0];
    it.window_high     = w[127:64];
    it.bytes_left      = avail;
    it.offset_mod_four = om4;
    it.address         = va;
    send_window(it);
  endtask

  function automatic in_item_t random_window();
    in_item_t     it;
    out_item_t    sized;
    logic [127:0] w;
    logic [7:0]   op;
    logic [31:0]  first, span, need;
    int unsigned  q, pick;
    w = {$urandom, $urandom, $urandom, $urandom};
    it.offset_mod_four = 2'($urandom_range(3));
    q = 4 - it.offset_mod_four;
    pick = $urandom_range(99);
    if (pick < 20) begin
      op = 8'($urandom);
    end else if (pick < 32) begin
      op = OP_TABLESWITCH;
      first = $urandom;
      span = ($urandom_range(9) == 0) ? $urandom : 32'($urandom_range(6));
      if ($urandom_range(9) == 0) span = 32'hFFFF_FFFF;
      w = put_be32(w, q + 4, first);
      w = put_be32(w, q + 8, first + span);
    end else if (pick < 44) begin
      op = OP_LOOKUPSWITCH;
      w = put_be32(w, q + 4, ($urandom_range(9) == 0) ? $urandom : 32'($urandom_range(6)));
    end else if (pick < 58) begin
      op = OP_WIDE;
      case ($urandom_range(3))
        0: w[15:8] = OP_IINC;
        1: w[15:8] = OP_ILOAD + 8'($urandom_range(OP_ALOAD - OP_ILOAD));
        2: w[15:8] = OP_ISTORE + 8'($urandom_range(OP_ASTORE - OP_ISTORE));
        default: w[15:8] = ($urandom_range(1) == 0) ? OP_RET : 8'($urandom);
      endcase
    end else if (pick < 74) begin
      case ($urandom_range(2))
        0: op = OP_IFEQ + 8'($urandom_range(OP_JSR - OP_IFEQ));
        1: op = ($urandom_range(1) == 0) ? OP_IFNULL : OP_IFNONNULL;
        default: op = ($urandom_range(1) == 0) ? OP_GOTO_W : OP_JSR_W;
      endcase
    end else begin
      case ($urandom_range(11))
        0: op = OP_BIPUSH;
        1: op = OP_SIPUSH;
        2: op = OP_LDC;
        3: op = ($urandom_range(1) == 0) ? OP_LDC_W : OP_LDC2_W;
        4: op = OP_ILOAD + 8'($urandom_range(OP_ALOAD - OP_ILOAD));
        5: op = OP_ISTORE + 8'($urandom_range(OP_ASTORE - OP_ISTORE));
        6: op = OP_RET;
        7: op = OP_IINC;
        8: op = OP_GETSTATIC + 8'($urandom_range(OP_INVOKESTATIC - OP_GETSTATIC));
        9: begin
          case ($urandom_range(3))
            0: op = OP_INVOKEINTERFACE;
            1: op = OP_INVOKEDYNAMIC;
            2: op = OP_NEWARRAY;
            default: op = OP_MULTIANEWARRAY;
          endcase
        end
        10: begin
          case ($urandom_range(3))
            0: op = OP_NEW;
            1: op = OP_ANEWARRAY;
            2: op = OP_CHECKCAST;
            default: op = OP_INSTANCEOF;
          endcase
        end
        default: op = ($urandom_range(1) == 0) ? OP_ATHROW :
                      OP_IRETURN + 8'($urandom_range(OP_RETURN - OP_IRETURN));
      endcase
    end
    w[7:0] = op;
    case ($urandom_range(3))
      0: it.address = {$urandom, $urandom};
      1: it.address = 64'($urandom_range(65535));
      2: it.address = 64'h7FFF_FFFF_FFFF_FFFF - 64'($urandom_range(65535));
      default: it.address = {1'b0, 31'($urandom), $urandom};
    endcase
    it.window_low  = w[63:0];
    it.window_high = w[127:64];
    it.bytes_left  = '1;
    sized = decode_window(it);
    need  = sized.length;
    // size the buffer around the real instruction length most of the time
    case ($urandom_range(9))
      0: it.bytes_left = $urandom;
      1: it.bytes_left = '1;
      2: it.bytes_left = 32'($urandom_range(3));
      3: it.bytes_left = need - 32'd1;
      default: it.bytes_left = need + 32'($urandom_range(3));
    endcase
    return it;
  endfunction

  task automatic run_directed();
    send_code(8'h00, 1, 32'd0, 2'd0, 64'h0);
    send_code(8'hFF, 1, 32'hFFFF_FFFF, 2'd3, 64'hFFFF_FFFF_FFFF_FFFF);
    send_code(OP_UNUSED_FIRST, 1, 32'd16, 2'd1, 64'h100);
    send_code(OP_UNUSED_LAST, 1, 32'd1, 2'd2, 64'h100);
    send_code({OP_BIPUSH, 8'h80}, 2, 32'd2, 2'd0, 64'h0);
    send_code({OP_SIPUSH, 16'h8000}, 3, 32'd2, 2'd0, 64'h0);
    send_code({OP_SIPUSH, 16'h7FFF}, 3, 32'd3, 2'd0, 64'h0);
    send_code({OP_LDC2_W, 16'hFFFF}, 3, 32'd3, 2'd1, 64'h0);
    send_code({OP_IINC, 8'hFF, 8'h80}, 3, 32'd3, 2'd2, 64'h0);
    send_code({OP_IFEQ, 16'h8000}, 3, 32'd3, 2'd0, 64'h10);
    send_code({OP_GOTO_W, 32'h8000_0000}, 5, 32'd5, 2'd0, 64'h8000_0000_0000_0000);
    send_code({OP_JSR_W, 32'h0000_0001}, 5, 32'd9, 2'd0, 64'h7FFF_FFFF_FFFF_FFFF);
    send_code({OP_TABLESWITCH, 32'h10, 32'h0, 32'h2}, 13, 32'd25, 2'd3, 64'h2000);
    send_code({OP_TABLESWITCH, 16'h0, 32'hFFFF_FFF0, 32'h5, 32'h4}, 15, 32'd100, 2'd1,
              64'h2000);
    send_code({OP_TABLESWITCH, 32'h10, 32'h0, 32'h2}, 13, 32'd24, 2'd3, 64'h2000);
    send_code({OP_LOOKUPSWITCH, 24'h0, 32'h8000_0000, 32'h1}, 12, 32'd20, 2'd0, 64'h0);
    send_code({OP_LOOKUPSWITCH, 32'h0, 32'hFFFF_FFFF}, 9, 32'hFFFF_FFFF, 2'd3, 64'h0);
    send_code({OP_WIDE, OP_IINC, 16'hFFFF, 16'h8000}, 6, 32'd6, 2'd0, 64'h0);
    send_code({OP_WIDE, OP_RET, 16'h1234}, 4, 32'd4, 2'd0, 64'h0);
    send_code({OP_WIDE, OP_ILOAD, 16'h0001}, 4, 32'd3, 2'd0, 64'h0);
    send_code({OP_WIDE, OP_BIPUSH, 16'h0001}, 4, 32'd16, 2'd0, 64'h0);
    send_code({OP_INVOKEINTERFACE, 16'hABCD, 8'h03, 8'h00}, 5, 32'd5, 2'd0, 64'h0);
    send_code({OP_INVOKEDYNAMIC, 16'h0102, 16'h0}, 5, 32'd5, 2'd0, 64'h0);
    send_code({OP_MULTIANEWARRAY, 16'hFFFF, 8'hFF}, 4, 32'd4, 2'd0, 64'h0);
    send_code({OP_NEWARRAY, 8'h0A}, 2, 32'd2, 2'd0, 64'h0);
    send_code(OP_ATHROW, 1, 32'd1, 2'd0, 64'h0);
  endtask

  initial begin
    decode_sb = new();
    rst_n                 <= 1'b0;
    in_ch.valid           <= 1'b0;
    in_ch.window_low      <= '0;
    in_ch.window_high     <= '0;
    in_ch.bytes_left      <= '0;
    in_ch.offset_mod_four <= '0;
    in_ch.address         <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    run_directed();
    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 55; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 55; end
        default: begin send_idle_pct = 32; stall_pct = 32; end
      endcase
      repeat (94) send_window(random_window());
    end
    in_ch.valid <= 1'b0;
    while (decode_sb.outstanding() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    decode_sb.check_drained();
    if (decode_sb.fault_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin
    #400_000;
    $display("simulation failed");
    $finish;
  end

endmodule
